// ----- rtl/mchw_pkg.sv -----
`timescale 1ns / 1ps

package mchw_pkg;

    // request codes carried in the func field
    typedef enum logic [2:0] {
        FUNC_ARM       = 3'd0,
        FUNC_DISARM    = 3'd1,
        FUNC_AFFIRM    = 3'd2,
        FUNC_TERMINATE = 3'd3,
        FUNC_TICK      = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        KIND_STATUS     = 2'd0,
        KIND_AFFIRM_REQ = 2'd1,
        KIND_REBOOT     = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_BAD_PARAM = 2'd1,
        ST_BELOW_MIN = 2'd2,
        ST_IGNORED   = 2'd3
    } status_t;

    typedef enum logic {
        REASON_MISSED    = 1'b0,
        REASON_FORBIDDEN = 1'b1
    } reason_t;

    typedef enum logic [1:0] {
        CELL_NOP,
        CELL_ARM,
        CELL_CLEAR,
        CELL_AFFIRM
    } cell_op_t;

    localparam int unsigned RES_CNT_W = 5;
    localparam logic [RES_CNT_W-1:0] MAX_RESULTS = 5'd16;
    localparam logic [15:0] MIN_PERIOD_RESET = 16'd100;

    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  channel;
        logic [15:0] period_ticks;
        logic        may_terminate;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] out_channel;
        logic [1:0] status;
        logic       reboot_reason;
        logic       last;
    } rsp_t;

    // request from the control to one watch cell
    typedef struct packed {
        cell_op_t    op;
        logic        may_terminate;
        logic [15:0] period_ticks;
    } cell_cmd_t;

    // tick scan control, shared by all cells
    typedef struct packed {
        logic start;
        logic step;
        logic abort;
    } scan_ctl_t;

    typedef struct packed {
        logic armed;
        logic term_ok;
        logic affirmed;
        logic hit;
    } cell_rpt_t;

endpackage

// ----- rtl/mchw_cell.sv -----
`timescale 1ns / 1ps

module mchw_cell #(
    parameter bit FIRST = 1'b0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  mchw_pkg::cell_cmd_t  cmd,
    input  mchw_pkg::scan_ctl_t  scan,
    input  logic                 tok_in,
    output logic                 tok_out,
    output mchw_pkg::cell_rpt_t  rpt
);
    import mchw_pkg::*;

    logic        armed_reg, armed_next;
    logic        aff_reg, aff_next;
    logic        term_ok_reg, term_ok_next;
    logic        active_reg, active_next;
    logic        tok_reg, tok_next;
    logic [15:0] reload_reg, reload_next;
    logic [15:0] cnt_reg, cnt_next;
    logic        expiring;
    logic        my_step;

    assign expiring = active_reg && (cnt_reg == 16'd1);
    assign my_step  = scan.step && tok_reg && active_reg;

    always_comb
    begin
        armed_next   = armed_reg;
        aff_next     = aff_reg;
        term_ok_next = term_ok_reg;
        active_next  = active_reg;
        reload_next  = reload_reg;
        cnt_next     = cnt_reg;

        if (en)
        begin
            case (cmd.op)
                CELL_ARM:
                begin
                    armed_next   = 1'b1;
                    aff_next     = 1'b0;
                    term_ok_next = cmd.may_terminate;
                    active_next  = (cmd.period_ticks != 16'd0);
                    reload_next  = cmd.period_ticks;
                    cnt_next     = cmd.period_ticks;
                end
                CELL_CLEAR:
                begin
                    armed_next   = 1'b0;
                    aff_next     = 1'b0;
                    term_ok_next = 1'b0;
                    active_next  = 1'b0;
                end
                CELL_AFFIRM:
                begin
                    aff_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else if (my_step)
        begin
            if (!expiring)
            begin
                cnt_next = cnt_reg - 16'd1;
            end
            else if (aff_reg)
            begin
                aff_next = 1'b0;
                cnt_next = reload_reg;
            end
            // unaffirmed expiry: block halts, state no longer matters
        end

        if (scan.start)
        begin
            tok_next = FIRST;
        end
        else if (scan.abort)
        begin
            tok_next = 1'b0;
        end
        else if (scan.step)
        begin
            tok_next = tok_in;
        end
        else
        begin
            tok_next = tok_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg   <= 1'b0;
            aff_reg     <= 1'b0;
            term_ok_reg <= 1'b0;
            active_reg  <= 1'b0;
            tok_reg     <= 1'b0;
        end
        else
        begin
            armed_reg   <= armed_next;
            aff_reg     <= aff_next;
            term_ok_reg <= term_ok_next;
            active_reg  <= active_next;
            tok_reg     <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        reload_reg <= reload_next;
        cnt_reg    <= cnt_next;
    end

    assign tok_out      = tok_reg;
    assign rpt.armed    = armed_reg;
    assign rpt.term_ok  = term_ok_reg;
    assign rpt.affirmed = aff_reg;
    assign rpt.hit      = tok_reg && expiring;

endmodule

// ----- rtl/multi_channel_heartbeat_watchdog.sv -----
`timescale 1ns / 1ps

// Heartbeat watchdog over CHANNELS client channels, one watch cell per channel.
// Arm, disarm, affirm and terminate requests pass their word through the pending
// word, then the output register; an arm that also sends an affirm request sends
// that request first. A tick passes a token along the row of cells, one cell per
// cycle while no hit that must be reported waits on the output side; a reboot
// demand ends the scan. A stall on the output side holds back any word that still
// has to move. The final word of every request carries last; a tick with no
// expiry gives no words. After a reboot demand all requests are taken and
// ignored until reset. The min_period_ticks register (reset 100) is written
// through the cfg channel, which is always ready.
module multi_channel_heartbeat_watchdog #(
    parameter int CHANNELS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  mchw_pkg::cmd_t   cmd,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output mchw_pkg::rsp_t   rsp,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [15:0]      cfg_data
);
    import mchw_pkg::*;

    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EMIT,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic                 halted_reg, halted_next;
    logic [15:0]          min_period_reg, min_period_next;
    logic                 pend_valid_reg, pend_valid_next;
    rsp_t                 pend_reg, pend_next;
    rsp_t                 hold_reg, hold_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;
    logic [IW-1:0]        scan_idx_reg, scan_idx_next;
    logic [RES_CNT_W-1:0] nres_reg, nres_next;

    cell_cmd_t            cell_cmd;
    logic                 cmd_en;
    scan_ctl_t            scan;
    cell_rpt_t            rpt_vec [CHANNELS];
    logic [CHANNELS-1:0]  armed_vec;
    logic [CHANNELS-1:0]  term_ok_vec;
    logic [CHANNELS-1:0]  aff_vec;
    logic [CHANNELS-1:0]  hit_vec;
    logic [CHANNELS:0]    tok_vec;

    logic                 accept;
    logic                 rsp_ready;
    logic                 can_push;
    logic                 push;
    rsp_t                 push_word;
    logic                 ch_ok;
    logic [IW+3:0]        ch_ext;
    logic [IW-1:0]        ch_idx;
    logic [IW+3:0]        scan_ext;
    logic                 armed_sel;
    logic                 term_ok_sel;
    logic                 hit;
    logic                 hit_aff;
    logic                 room;
    logic                 at_last;
    rsp_t                 word;

    assign tok_vec[0] = 1'b0;

    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_cell
        mchw_cell #(
            .FIRST (i == 0)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (cmd_en && (ch_idx == IW'(i))),
            .cmd     (cell_cmd),
            .scan    (scan),
            .tok_in  (tok_vec[i]),
            .tok_out (tok_vec[i+1]),
            .rpt     (rpt_vec[i])
        );
        assign armed_vec[i]   = rpt_vec[i].armed;
        assign term_ok_vec[i] = rpt_vec[i].term_ok;
        assign aff_vec[i]     = rpt_vec[i].affirmed;
        assign hit_vec[i]     = rpt_vec[i].hit;
    end

    assign ch_ext      = (IW+4)'(cmd.channel);
    assign ch_idx      = ch_ext[IW-1:0];
    assign ch_ok       = (32'(cmd.channel) < 32'(CHANNELS));
    assign armed_sel   = armed_vec[ch_idx];
    assign term_ok_sel = term_ok_vec[ch_idx];
    assign scan_ext    = (IW+4)'(scan_idx_reg);

    // only the cell holding the token can report a hit
    assign hit     = |hit_vec;
    assign hit_aff = |(hit_vec & aff_vec);
    assign at_last = tok_vec[CHANNELS];
    assign room    = (nres_reg < MAX_RESULTS);

    assign accept    = cmd_valid && !cmd_stall;
    assign rsp_ready = !rsp_valid_reg || !rsp_stall;
    assign can_push  = !pend_valid_reg || rsp_ready;

    always_comb
    begin
        state_next      = state_reg;
        halted_next     = halted_reg;
        min_period_next = cfg_valid ? cfg_data : min_period_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        hold_next       = hold_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_next        = rsp_reg;
        scan_idx_next   = scan_idx_reg;
        nres_next       = nres_reg;

        cell_cmd.op            = CELL_NOP;
        cell_cmd.may_terminate = cmd.may_terminate;
        cell_cmd.period_ticks  = cmd.period_ticks;
        cmd_en                 = 1'b0;
        scan                   = '0;
        push                   = 1'b0;
        push_word              = '0;

        word               = '0;
        word.kind          = KIND_STATUS;
        word.out_channel   = cmd.channel;
        word.status        = ST_DONE;
        word.reboot_reason = REASON_MISSED;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && !halted_reg)
                begin
                    if (cmd.func == FUNC_TICK)
                    begin
                        scan.start    = 1'b1;
                        scan_idx_next = '0;
                        nres_next     = '0;
                        state_next    = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                        if ((cmd.func inside {FUNC_ARM, FUNC_DISARM, FUNC_AFFIRM,
                                              FUNC_TERMINATE}) && !ch_ok)
                        begin
                            word.status = ST_BAD_PARAM;
                        end
                        else
                        begin
                            case (cmd.func)
                                FUNC_ARM:
                                begin
                                    if ((cmd.period_ticks == 16'd0) && cmd.may_terminate)
                                    begin
                                        word.status = ST_BAD_PARAM;
                                    end
                                    else if ((cmd.period_ticks != 16'd0) &&
                                             (cmd.period_ticks < min_period_reg))
                                    begin
                                        word.status = ST_BELOW_MIN;
                                    end
                                    else if (armed_sel)
                                    begin
                                        word.status = ST_IGNORED;
                                    end
                                    else
                                    begin
                                        cell_cmd.op = CELL_ARM;
                                        cmd_en      = 1'b1;
                                        if (cmd.period_ticks != 16'd0)
                                        begin
                                            // affirm request first, done status next
                                            hold_next  = word;
                                            word.kind  = KIND_AFFIRM_REQ;
                                            state_next = S_EMIT;
                                        end
                                    end
                                end
                                FUNC_DISARM:
                                begin
                                    cell_cmd.op = CELL_CLEAR;
                                    cmd_en      = 1'b1;
                                end
                                FUNC_AFFIRM:
                                begin
                                    if (armed_sel)
                                    begin
                                        cell_cmd.op = CELL_AFFIRM;
                                        cmd_en      = 1'b1;
                                    end
                                    else
                                    begin
                                        word.status = ST_IGNORED;
                                    end
                                end
                                FUNC_TERMINATE:
                                begin
                                    if (!armed_sel)
                                    begin
                                        word.status = ST_IGNORED;
                                    end
                                    else if (term_ok_sel)
                                    begin
                                        cell_cmd.op = CELL_CLEAR;
                                        cmd_en      = 1'b1;
                                    end
                                    else
                                    begin
                                        word.kind          = KIND_REBOOT;
                                        word.reboot_reason = REASON_FORBIDDEN;
                                        halted_next        = 1'b1;
                                    end
                                end
                                default:
                                begin
                                    word.status = ST_IGNORED;
                                end
                            endcase
                        end
                        push      = 1'b1;
                        push_word = word;
                    end
                end
            end

            S_EMIT:
            begin
                push      = 1'b1;
                push_word = hold_reg;
                if (can_push)
                begin
                    state_next = S_FINISH;
                end
            end

            S_SCAN:
            begin
                word.out_channel = scan_ext[3:0];
                word.kind        = hit_aff ? KIND_AFFIRM_REQ : KIND_REBOOT;
                // past the result limit the scan carries on without reporting
                if (!hit || !room || can_push)
                begin
                    scan.step = 1'b1;
                    if (hit && room)
                    begin
                        push      = 1'b1;
                        push_word = word;
                        nres_next = nres_reg + 1'b1;
                    end
                    if (hit && !hit_aff)
                    begin
                        scan.abort  = 1'b1;
                        halted_next = 1'b1;
                        state_next  = S_FINISH;
                    end
                    else if (at_last)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
            end

            S_FINISH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (rsp_ready)
                begin
                    rsp_next        = pend_reg;
                    rsp_next.last   = 1'b1;
                    rsp_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a new word displaces the pending one into the output register
        if (push && can_push)
        begin
            if (pend_valid_reg)
            begin
                rsp_next       = pend_reg;
                rsp_next.last  = 1'b0;
                rsp_valid_next = 1'b1;
            end
            pend_next       = push_word;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            halted_reg     <= 1'b0;
            min_period_reg <= MIN_PERIOD_RESET;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            scan_idx_reg   <= '0;
            nres_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            halted_reg     <= halted_next;
            min_period_reg <= min_period_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
            scan_idx_reg   <= scan_idx_next;
            nres_reg       <= nres_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        hold_reg <= hold_next;
        rsp_reg  <= rsp_next;
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

endmodule

// ----- dv/multi_channel_heartbeat_watchdog_test.sv -----
`timescale 1ns / 1ps

module multi_channel_heartbeat_watchdog_test;

    import mchw_pkg::*;

    localparam int CHANNELS = 16;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 2 * CHANNELS + 8;
    localparam logic [2:0] FUNC_UNDEF_LO = 3'd5;
    localparam logic [2:0] FUNC_UNDEF_HI = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    cmd_t        cmd = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_t        rsp;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    // shadow of the watchdog state
    logic        armed     [CHANNELS];
    logic        affirmed  [CHANNELS];
    logic        term_ok   [CHANNELS];
    logic        timing    [CHANNELS];
    logic [15:0] reload    [CHANNELS];
    logic [15:0] countdown [CHANNELS];
    logic        halted;
    logic [15:0] min_period;

    rsp_t pending_replies[$];
    rsp_t front_reply;

    int error_count = 0;
    int words_sent = 0;
    int replies_checked = 0;
    int affirm_reqs_seen = 0;
    int reboots_seen = 0;
    int idle_cycles = 0;
    int send_gap_pct = 0;
    int stall_pct = 0;

    multi_channel_heartbeat_watchdog #(.CHANNELS(CHANNELS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void queue_reply(kind_t k, int ch, status_t s, reason_t r);
        rsp_t w;
        w.kind = k;
        w.out_channel = 4'(ch);
        w.status = s;
        w.reboot_reason = r;
        w.last = 1'b0;
        pending_replies.push_back(w);
    endfunction

    function automatic void clear_shadow(int ch);
        armed[ch] = 1'b0;
        affirmed[ch] = 1'b0;
        term_ok[ch] = 1'b0;
        timing[ch] = 1'b0;
    endfunction

    function automatic void reset_shadow();
        for (int i = 0; i < CHANNELS; i++)
        begin
            clear_shadow(i);
            reload[i] = '0;
            countdown[i] = '0;
        end
        halted = 1'b0;
        min_period = MIN_PERIOD_RESET;
    endfunction

    // works out the replies to one accepted command word and updates the shadow
    function automatic void forecast_replies(cmd_t c);
        int n;
        int ch;
        rsp_t w;
        n = 0;
        ch = int'(c.channel);
        if (halted)
            return;
        if (c.func == FUNC_TICK)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (!timing[i])
                    continue;
                countdown[i] = countdown[i] - 16'd1;
                if (countdown[i] != '0)
                    continue;
                n++;
                if (affirmed[i])
                begin
                    affirmed[i] = 1'b0;
                    countdown[i] = reload[i];
                    queue_reply(KIND_AFFIRM_REQ, i, ST_DONE, REASON_MISSED);
                end
                else
                begin
                    queue_reply(KIND_REBOOT, i, ST_DONE, REASON_MISSED);
                    halted = 1'b1;
                    break;
                end
            end
        end
        else if (c.func > FUNC_TICK)
        begin
            queue_reply(KIND_STATUS, ch, ST_IGNORED, REASON_MISSED);
            n++;
        end
        else if (c.func == FUNC_ARM)
        begin
            n++;
            if (c.period_ticks == '0 && c.may_terminate)
                queue_reply(KIND_STATUS, ch, ST_BAD_PARAM, REASON_MISSED);
            else if (c.period_ticks != '0 && c.period_ticks < min_period)
                queue_reply(KIND_STATUS, ch, ST_BELOW_MIN, REASON_MISSED);
            else if (armed[ch])
                queue_reply(KIND_STATUS, ch, ST_IGNORED, REASON_MISSED);
            else
            begin
                armed[ch] = 1'b1;
                affirmed[ch] = 1'b0;
                term_ok[ch] = c.may_terminate;
                timing[ch] = 1'b0;
                if (c.period_ticks != '0)
                begin
                    reload[ch] = c.period_ticks;
                    countdown[ch] = c.period_ticks;
                    timing[ch] = 1'b1;
                    queue_reply(KIND_AFFIRM_REQ, ch, ST_DONE, REASON_MISSED);
                    n++;
                end
                queue_reply(KIND_STATUS, ch, ST_DONE, REASON_MISSED);
            end
        end
        else if (c.func == FUNC_DISARM)
        begin
            clear_shadow(ch);
            queue_reply(KIND_STATUS, ch, ST_DONE, REASON_MISSED);
            n++;
        end
        else if (c.func == FUNC_AFFIRM)
        begin
            n++;
            if (armed[ch])
            begin
                affirmed[ch] = 1'b1;
                queue_reply(KIND_STATUS, ch, ST_DONE, REASON_MISSED);
            end
            else
                queue_reply(KIND_STATUS, ch, ST_IGNORED, REASON_MISSED);
        end
        else
        begin
            n++;
            if (!armed[ch])
                queue_reply(KIND_STATUS, ch, ST_IGNORED, REASON_MISSED);
            else if (term_ok[ch])
            begin
                clear_shadow(ch);
                queue_reply(KIND_STATUS, ch, ST_DONE, REASON_MISSED);
            end
            else
            begin
                queue_reply(KIND_REBOOT, ch, ST_DONE, REASON_FORBIDDEN);
                halted = 1'b1;
            end
        end
        if (n > 0)
        begin
            w = pending_replies[pending_replies.size() - 1];
            w.last = 1'b1;
            pending_replies[pending_replies.size() - 1] = w;
        end
    endfunction

    // valid stays high between back-to-back words; it drops only for a gap or in settle
    task automatic send_word(logic [2:0] f, logic [3:0] ch, logic [15:0] p, logic mt);
        cmd_t c;
        c.func = f;
        c.channel = ch;
        c.period_ticks = p;
        c.may_terminate = mt;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (cmd_stall);
        forecast_replies(c);
        words_sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        // a tick with no expiry may still be scanning
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_min_period(logic [15:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        min_period = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_arm_checks();
        send_word(FUNC_ARM, 4'd0, 16'd0, 1'b1);
        send_word(FUNC_ARM, 4'd1, MIN_PERIOD_RESET - 16'd1, 1'b0);
        send_word(FUNC_ARM, 4'd2, MIN_PERIOD_RESET, 1'b1);
        send_word(FUNC_ARM, 4'd2, MIN_PERIOD_RESET, 1'b1);
        send_word(FUNC_ARM, 4'd3, 16'd0, 1'b0);
        send_word(FUNC_ARM, 4'd15, 16'hFFFF, 1'b0);
    endtask

    task automatic test_channel_requests();
        send_word(FUNC_AFFIRM, 4'd4, 16'hFFFF, 1'b1);
        send_word(FUNC_TERMINATE, 4'd4, 16'd0, 1'b0);
        send_word(FUNC_AFFIRM, 4'd3, 16'd0, 1'b0);
        send_word(FUNC_TERMINATE, 4'd2, 16'd0, 1'b0);
        send_word(FUNC_DISARM, 4'd5, 16'd0, 1'b0);
    endtask

    task automatic test_unknown_func();
        int f;
        for (f = int'(FUNC_UNDEF_LO); f <= int'(FUNC_UNDEF_HI); f++)
            send_word(3'(f), 4'd15, 16'hFFFF, 1'b1);
    endtask

    task automatic test_tick_expiry();
        settle();
        write_min_period(16'd1);
        send_word(FUNC_ARM, 4'd0, 16'd1, 1'b0);
        send_word(FUNC_ARM, 4'd1, 16'd2, 1'b1);
        send_word(FUNC_AFFIRM, 4'd0, 16'd0, 1'b0);
        send_word(FUNC_AFFIRM, 4'd1, 16'd0, 1'b0);
        send_word(FUNC_TICK, 4'd0, 16'd0, 1'b0);
        send_word(FUNC_AFFIRM, 4'd0, 16'd0, 1'b0);
        // both channels expire affirmed: two requests in one tick
        send_word(FUNC_TICK, 4'd0, 16'd0, 1'b0);
        send_word(FUNC_DISARM, 4'd0, 16'd0, 1'b0);
        send_word(FUNC_DISARM, 4'd1, 16'd0, 1'b0);
        send_word(FUNC_TICK, 4'd0, 16'd0, 1'b0);
        send_word(FUNC_DISARM, 4'd15, 16'd0, 1'b0);
    endtask

    // affirm every channel that the next tick would otherwise expire unaffirmed
    task automatic guard_expiries();
        for (int i = 0; i < CHANNELS; i++)
            if (!halted && timing[i] && countdown[i] == 16'd1 && !affirmed[i])
                send_word(FUNC_AFFIRM, 4'(i), 16'($urandom()), 1'($urandom()));
    endtask

    task automatic test_random(int items);
        int r;
        int sel;
        logic [3:0]  ch;
        logic [15:0] p;
        logic        mt;
        for (int k = 0; k < items; k++)
        begin
            r = $urandom_range(0, 99);
            ch = 4'($urandom_range(0, CHANNELS - 1));
            p = 16'($urandom());
            mt = 1'($urandom());
            if (r < 25)
            begin
                sel = $urandom_range(0, 9);
                if (sel == 0)
                    p = '0;
                else if (sel == 3)
                    p = min_period - 16'd1;
                else if (sel > 3)
                    p = (min_period > 16'd65531) ? 16'hFFFF
                                                 : min_period + 16'($urandom_range(0, 4));
                send_word(FUNC_ARM, ch, p, mt);
            end
            else if (r < 33)
                send_word(FUNC_DISARM, ch, p, mt);
            else if (r < 55)
                send_word(FUNC_AFFIRM, ch, p, mt);
            else if (r < 65)
            begin
                // a forbidden terminate would halt the block; keep that for the end
                if (armed[ch] && !term_ok[ch])
                    send_word(FUNC_DISARM, ch, p, mt);
                else
                    send_word(FUNC_TERMINATE, ch, p, mt);
            end
            else if (r < 92)
            begin
                guard_expiries();
                send_word(FUNC_TICK, ch, p, mt);
            end
            else
                send_word(FUNC_UNDEF_LO + 3'($urandom_range(0, 2)), ch, p, mt);
        end
    endtask

    task automatic test_random_phases();
        logic [15:0] phase_min [4];
        int gap_by_phase [4];
        int stall_by_phase [4];
        phase_min[0] = 16'd1;
        phase_min[1] = 16'hFFFF;
        phase_min[2] = 16'($urandom_range(1, 3));
        phase_min[3] = 16'($urandom_range(1, 65535));
        gap_by_phase = '{0, 52, 0, 33};
        stall_by_phase = '{0, 0, 52, 33};
        // the random minimum is mostly too large for expiries, so the stalling
        // phase, where most expiries are wanted, gets a small one
        for (int ph = 0; ph < 4; ph++)
        begin
            settle();
            write_min_period(phase_min[ph]);
            send_gap_pct = gap_by_phase[ph];
            stall_pct = stall_by_phase[ph];
            test_random(24);
        end
        send_gap_pct = 0;
        stall_pct = 0;
    endtask

    task automatic test_reboot_and_halt();
        logic [3:0] ch;
        settle();
        write_min_period(16'd1);
        ch = 4'($urandom_range(0, CHANNELS - 1));
        send_word(FUNC_DISARM, ch, 16'd0, 1'b0);
        if ($urandom_range(0, 1))
        begin
            send_word(FUNC_ARM, ch, 16'd0, 1'b0);
            send_word(FUNC_TERMINATE, ch, 16'd0, 1'b0);
        end
        else
        begin
            send_word(FUNC_ARM, ch, 16'd1, 1'($urandom()));
            send_word(FUNC_TICK, 4'd0, 16'd0, 1'b0);
        end
        // halted: every word is taken and nothing comes back
        send_word(FUNC_ARM, 4'($urandom()), 16'hFFFF, 1'b0);
        send_word(FUNC_DISARM, 4'($urandom()), 16'($urandom()), 1'b1);
        send_word(FUNC_AFFIRM, ch, 16'($urandom()), 1'b0);
        send_word(FUNC_TERMINATE, ch, 16'($urandom()), 1'b1);
        send_word(FUNC_TICK, 4'($urandom()), 16'($urandom()), 1'b0);
        send_word(FUNC_UNDEF_HI, 4'($urandom()), 16'($urandom()), 1'b1);
    endtask

    always @(negedge clk)
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            replies_checked++;
            if (rsp.kind == KIND_AFFIRM_REQ)
                affirm_reqs_seen++;
            if (rsp.kind == KIND_REBOOT)
                reboots_seen++;
            if (pending_replies.size() == 0)
            begin
                $error("unexpected reply word: kind %0d channel %0d status %0d",
                       rsp.kind, rsp.out_channel, rsp.status);
                error_count++;
            end
            else
            begin
                front_reply = pending_replies.pop_front();
                if (rsp.kind !== front_reply.kind)
                begin
                    $error("kind: expected %0d, got %0d", front_reply.kind, rsp.kind);
                    error_count++;
                end
                if (rsp.out_channel !== front_reply.out_channel)
                begin
                    $error("out_channel: expected %0d, got %0d",
                           front_reply.out_channel, rsp.out_channel);
                    error_count++;
                end
                if (rsp.status !== front_reply.status)
                begin
                    $error("status: expected %0d, got %0d", front_reply.status, rsp.status);
                    error_count++;
                end
                if (rsp.reboot_reason !== front_reply.reboot_reason)
                begin
                    $error("reboot_reason: expected %0d, got %0d",
                           front_reply.reboot_reason, rsp.reboot_reason);
                    error_count++;
                end
                if (rsp.last !== front_reply.last)
                begin
                    $error("last: expected %0d, got %0d", front_reply.last, rsp.last);
                    error_count++;
                end
            end
        end
    end

    // run stops if no channel moves a word for too long
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d quiet cycles, %0d replies outstanding",
                     idle_cycles, pending_replies.size());
            $display("multi_channel_heartbeat_watchdog_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        reset_shadow();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_arm_checks();
        test_channel_requests();
        test_unknown_func();
        test_tick_expiry();
        test_random_phases();
        test_reboot_and_halt();
        settle();

        $display("covered arm checks, affirm/terminate/disarm, unknown codes, tick expiry,");
        $display("halt after reboot: %0d words in, %0d replies (%0d affirm requests, %0d reboots)",
                 words_sent, replies_checked, affirm_reqs_seen, reboots_seen);
        if (error_count == 0)
            $display("multi_channel_heartbeat_watchdog_test: done, clean");
        else
            $display("multi_channel_heartbeat_watchdog_test: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/mchw_pkg.sv
rtl/mchw_cell.sv
rtl/multi_channel_heartbeat_watchdog.sv
dv/multi_channel_heartbeat_watchdog_test.sv
